// ===== sv/fssd_pkg.sv =====
// ============================================================================
// Film slope stability detector package
// Shared types, register indexes and fixed widths of the detector.
// ============================================================================
package fssd_pkg;

    localparam int TEMP_W = 16;
    localparam int DIFF_W = 17;
    localparam int CFG_W  = 16;
    localparam int RUN_W  = 16;
    localparam int IDX_W  = 2;

    // Command codes carried on the input tuser bit
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SLOPE_LIMIT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_STABLE_NEEDED = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILM_SETPOINT = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] SLOPE_LIMIT_RST   = 16'd5;
    localparam logic [CFG_W-1:0] STABLE_NEEDED_RST = 16'd10;
    localparam logic [CFG_W-1:0] FILM_SETPOINT_RST = 16'd26;

    localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

    // Control and payload of one item between the window stage and the judge
    typedef struct packed {
        logic                     clear;      // clear command, no sample
        logic                     short_win;  // fewer than two samples held
        logic signed [DIFF_W-1:0] diff;       // mirror minus reference
    } stage_t;

endpackage

// ===== sv/fssd_window.sv =====
// ============================================================================
// Film slope detector sample window
// Ring memory of temperature differences with write pointer and fill flag;
// registers each accepted item together with the oldest held difference.
// ============================================================================
module fssd_window #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                cmd,
    input  logic signed [fssd_pkg::TEMP_W-1:0]  mirror_temp,
    input  logic signed [fssd_pkg::TEMP_W-1:0]  ref_temp,
    output fssd_pkg::stage_t                    stage,
    output logic signed [fssd_pkg::DIFF_W-1:0]  oldest,
    output logic [AW-1:0]                       span
);

    logic signed [fssd_pkg::DIFF_W-1:0] window_mem [DEPTH];

    logic [AW-1:0]                      wp_reg;
    logic [AW-1:0]                      wp_next;
    logic                               full_reg;
    logic                               full_next;
    logic                               wrap;
    logic [AW-1:0]                      rd_idx;
    logic signed [fssd_pkg::DIFF_W-1:0] diff;

    fssd_pkg::stage_t                   stage_reg;
    fssd_pkg::stage_t                   stage_next;
    logic signed [fssd_pkg::DIFF_W-1:0] oldest_reg;
    logic [AW-1:0]                      span_reg;
    logic [AW-1:0]                      span_next;

    assign diff = $signed({mirror_temp[fssd_pkg::TEMP_W-1], mirror_temp})
                - $signed({ref_temp[fssd_pkg::TEMP_W-1], ref_temp});

    assign wrap      = (wp_reg == AW'(DEPTH - 1));
    assign wp_next   = wrap ? '0 : wp_reg + AW'(1);
    assign full_next = full_reg | wrap;

    // oldest entry: slot zero until the ring wraps, then the slot after the newest
    assign rd_idx = full_next ? wp_next : '0;

    always_comb begin
        stage_next.clear     = (cmd == fssd_pkg::CMD_CLEAR);
        stage_next.short_win = !full_next && (wp_reg == '0);
        stage_next.diff      = diff;
        span_next            = full_next ? AW'(DEPTH - 1) : wp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end else if (accept) begin
            if (cmd == fssd_pkg::CMD_CLEAR) begin
                wp_reg   <= '0;
                full_reg <= 1'b0;
            end else begin
                wp_reg   <= wp_next;
                full_reg <= full_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg  <= stage_next;
            span_reg   <= span_next;
            oldest_reg <= window_mem[rd_idx];
            if (cmd != fssd_pkg::CMD_CLEAR) begin
                window_mem[wp_reg] <= diff;
            end
        end
    end

    assign stage  = stage_reg;
    assign oldest = oldest_reg;
    assign span   = span_reg;

endmodule

// ===== sv/fssd_judge.sv =====
// ============================================================================
// Film slope detector judge
// Slope test by cross-multiplication, stable run counter and result register.
// ============================================================================
module fssd_judge #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  fssd_pkg::stage_t                    stage,
    input  logic signed [fssd_pkg::DIFF_W-1:0]  oldest,
    input  logic [AW-1:0]                       span,
    input  logic [fssd_pkg::CFG_W-1:0]          slope_limit,
    input  logic [fssd_pkg::CFG_W-1:0]          stable_needed,
    input  logic [fssd_pkg::CFG_W-1:0]          film_setpoint,
    output logic                                stable,
    output logic signed [fssd_pkg::DIFF_W-1:0]  setpoint_out,
    output logic signed [fssd_pkg::DIFF_W-1:0]  temp_diff
);

    localparam int MAG_W = fssd_pkg::DIFF_W + 1;
    localparam int PW    = (fssd_pkg::CFG_W + AW > MAG_W + 4) ? fssd_pkg::CFG_W + AW
                                                              : MAG_W + 4;

    logic signed [MAG_W-1:0]            delta;
    logic [MAG_W-1:0]                   mag;
    logic [PW-1:0]                      mag10;
    logic [PW-1:0]                      lim_prod;
    logic                               slope_ok;

    logic [fssd_pkg::RUN_W-1:0]         run_reg;
    logic [fssd_pkg::RUN_W-1:0]         run_next;

    logic                               stable_reg;
    logic                               stable_next;
    logic signed [fssd_pkg::DIFF_W-1:0] setpoint_reg;
    logic signed [fssd_pkg::DIFF_W-1:0] diff_reg;
    logic signed [fssd_pkg::DIFF_W-1:0] diff_next;

    assign delta    = $signed({stage.diff[fssd_pkg::DIFF_W-1], stage.diff})
                    - $signed({oldest[fssd_pkg::DIFF_W-1], oldest});
    assign mag      = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
    assign mag10    = (PW'(mag) << 3) + (PW'(mag) << 1);
    assign lim_prod = PW'(slope_limit) * PW'(span);

    // with fewer than two samples the slope is zero
    assign slope_ok = stage.short_win ? (slope_limit != '0) : (mag10 < lim_prod);

    always_comb begin
        if (stage.clear) begin
            run_next = '0;
        end else if (slope_ok) begin
            run_next = (run_reg == fssd_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;
        end else begin
            run_next = '0;
        end
        stable_next = stage.clear ? 1'b0 : (run_next >= stable_needed);
        diff_next   = stage.clear ? '0 : stage.diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (advance) begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stable_reg   <= stable_next;
            setpoint_reg <= -$signed({1'b0, film_setpoint});
            diff_reg     <= diff_next;
        end
    end

    assign stable       = stable_reg;
    assign setpoint_out = setpoint_reg;
    assign temp_diff    = diff_reg;

endmodule

// ===== sv/film_slope_stability_detector_core.sv =====
// ============================================================================
// Film slope stability detector core
// Windowed slope test on mirror/reference temperature differences with a
// stable-run counter; one result transfer for every input transfer.
// ============================================================================
// Each input transfer is a sample (tuser 0) or a clear command (tuser 1).
// A sample stores mirror minus reference in a ring window of WINDOW_DEPTH
// entries, compares newest minus oldest against the slope limit scaled by
// the number of held samples less one, and counts consecutive stable
// samples; the result reports stable once that count reaches stable_needed,
// together with the negated film setpoint and this sample's difference.
// The block takes one item per clock while the result side keeps up. The
// window stage writes the window memory and registers the oldest entry,
// read through its single read port; the judge stage does the slope test
// and run counter. Backpressure on the result side stalls both stages;
// the input stage keeps accepting while it is empty. Configuration writes
// are taken at any time but should land only while no item is in flight.
// ============================================================================
module film_slope_stability_detector_core #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // mirror_temp[15:0], ref_temp[31:16]
    input  logic                              s_tuser,   // command

    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // stable[0], setpoint_out[17:1],
                                                         // temp_diff[34:18], zero[39:35]

    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fssd_pkg::IDX_W-1:0]        cfg_index,
    input  logic [fssd_pkg::CFG_W-1:0]        cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [fssd_pkg::CFG_W-1:0]          slope_limit_reg;
    logic [fssd_pkg::CFG_W-1:0]          stable_needed_reg;
    logic [fssd_pkg::CFG_W-1:0]          film_setpoint_reg;

    logic                                in_valid_reg;
    logic                                out_valid_reg;
    logic                                out_free;
    logic                                in_accept;
    logic                                advance;

    fssd_pkg::stage_t                    stage;
    logic signed [fssd_pkg::DIFF_W-1:0]  oldest;
    logic [AW-1:0]                       span;

    logic                                stable;
    logic signed [fssd_pkg::DIFF_W-1:0]  setpoint_out;
    logic signed [fssd_pkg::DIFF_W-1:0]  temp_diff;

    // Configuration: always ready, ignore indexes beyond the register list
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_limit_reg   <= fssd_pkg::SLOPE_LIMIT_RST;
            stable_needed_reg <= fssd_pkg::STABLE_NEEDED_RST;
            film_setpoint_reg <= fssd_pkg::FILM_SETPOINT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                fssd_pkg::REG_SLOPE_LIMIT:   slope_limit_reg   <= cfg_data;
                fssd_pkg::REG_STABLE_NEEDED: stable_needed_reg <= cfg_data;
                fssd_pkg::REG_FILM_SETPOINT: film_setpoint_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Flow control: the result register frees when empty or taken; the input
    // stage takes a new transfer when it is empty or moving on
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;
    assign advance   = in_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    fssd_window #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .cmd         (s_tuser),
        .mirror_temp (s_tdata[15:0]),
        .ref_temp    (s_tdata[31:16]),
        .stage       (stage),
        .oldest      (oldest),
        .span        (span)
    );

    fssd_judge #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_judge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .stage         (stage),
        .oldest        (oldest),
        .span          (span),
        .slope_limit   (slope_limit_reg),
        .stable_needed (stable_needed_reg),
        .film_setpoint (film_setpoint_reg),
        .stable        (stable),
        .setpoint_out  (setpoint_out),
        .temp_diff     (temp_diff)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, temp_diff, setpoint_out, stable};

`ifndef SYNTHESIS
    // Input stalls only when both stages are full and the result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    // A clear command yields a result with stable low and zero difference
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage.clear) |=> (m_tvalid && !stable && temp_diff == '0))
        else $error("clear result not zero");

    // A moving item always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("item lost between stages");

    // Register write takes effect on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == fssd_pkg::REG_SLOPE_LIMIT)
            |=> (slope_limit_reg == $past(cfg_data)))
        else $error("slope limit write lost");
`endif

endmodule

// ===== tb/fssd_tb_pkg.sv =====
// ============================================================================
// Film slope stability detector testbench package
// Result record and a scoreboard that tracks the sample window, the stable
// run and the registers, and checks every result transfer against them.
// ============================================================================
package fssd_tb_pkg;

    localparam int RING_DEPTH = 16;
    localparam int POS_W      = $clog2(RING_DEPTH);
    localparam int REPORT_MAX = 10;

    // Index past the register list; writes to it must change nothing
    localparam logic [fssd_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic                               stable;
        logic signed [fssd_pkg::DIFF_W-1:0] setpoint;
        logic signed [fssd_pkg::DIFF_W-1:0] diff;
    } film_report_t;

    class film_stability_tracker;

        logic [fssd_pkg::CFG_W-1:0]         slope_limit;
        logic [fssd_pkg::CFG_W-1:0]         stable_needed;
        logic [fssd_pkg::CFG_W-1:0]         film_setpoint;

        logic signed [fssd_pkg::DIFF_W-1:0] diff_ring [RING_DEPTH];
        logic [POS_W-1:0]                   wr_pos;
        bit                                 ring_full;
        logic [fssd_pkg::RUN_W-1:0]         run_len;

        film_report_t                       pending_reports [$];
        int                                 mismatches;

        function new();
            slope_limit   = fssd_pkg::SLOPE_LIMIT_RST;
            stable_needed = fssd_pkg::STABLE_NEEDED_RST;
            film_setpoint = fssd_pkg::FILM_SETPOINT_RST;
            wr_pos        = '0;
            ring_full     = 1'b0;
            run_len       = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [fssd_pkg::IDX_W-1:0] idx,
                                logic [fssd_pkg::CFG_W-1:0] val);
            case (idx)
                fssd_pkg::REG_SLOPE_LIMIT:   slope_limit   = val;
                fssd_pkg::REG_STABLE_NEEDED: stable_needed = val;
                fssd_pkg::REG_FILM_SETPOINT: film_setpoint = val;
                default: ;
            endcase
        endfunction

        // Newest minus oldest over the held samples, tested without division
        function bit slope_within_limit();
            longint oldest;
            longint newest;
            longint swing;
            int     held;
            if (!ring_full && wr_pos < 2)
                return slope_limit != '0;
            if (ring_full) begin
                held   = RING_DEPTH;
                oldest = diff_ring[wr_pos];
            end else begin
                held   = int'(wr_pos);
                oldest = diff_ring[0];
            end
            newest = diff_ring[POS_W'(wr_pos - 1'b1)];
            swing  = newest - oldest;
            if (swing < 0)
                swing = -swing;
            return swing * 10 < longint'(slope_limit) * (held - 1);
        endfunction

        function void take_input(logic cmd, logic signed [fssd_pkg::TEMP_W-1:0] mir,
                                 logic signed [fssd_pkg::TEMP_W-1:0] rtemp);
            film_report_t want;
            int           delta;
            int           neg_sp;
            neg_sp        = -int'(film_setpoint);
            want.setpoint = neg_sp[fssd_pkg::DIFF_W-1:0];
            if (cmd == fssd_pkg::CMD_CLEAR) begin
                wr_pos      = '0;
                ring_full   = 1'b0;
                run_len     = '0;
                want.stable = 1'b0;
                want.diff   = '0;
            end else begin
                delta             = int'(mir) - int'(rtemp);
                diff_ring[wr_pos] = delta[fssd_pkg::DIFF_W-1:0];
                wr_pos            = wr_pos + 1'b1;
                if (wr_pos == '0)
                    ring_full = 1'b1;
                if (slope_within_limit()) begin
                    if (run_len != fssd_pkg::RUN_MAX)
                        run_len = run_len + 1'b1;
                end else begin
                    run_len = '0;
                end
                want.stable = (run_len >= stable_needed);
                want.diff   = delta[fssd_pkg::DIFF_W-1:0];
            end
            pending_reports.push_back(want);
        endfunction

        function void note_miss(string what, film_report_t want, film_report_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch on %s: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                         what, want.stable, want.setpoint, want.diff,
                         got.stable, got.setpoint, got.diff);
        endfunction

        function void check_result(logic [39:0] word);
            film_report_t got;
            film_report_t want;
            got.stable   = word[0];
            got.setpoint = word[17:1];
            got.diff     = word[34:18];
            if (pending_reports.size() == 0) begin
                note_miss("unrequested result", got, got);
                return;
            end
            want = pending_reports.pop_front();
            if (got.stable !== want.stable)
                note_miss("stable", want, got);
            if (got.setpoint !== want.setpoint)
                note_miss("setpoint_out", want, got);
            if (got.diff !== want.diff)
                note_miss("temp_diff", want, got);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

    endclass

endpackage

// ===== tb/tb_top.sv =====
// ============================================================================
// Film slope stability detector testbench
// Drives samples and clear commands through the detector under several
// register settings, with random pacing on both streams, and checks each
// result transfer against the scoreboard's own window and run counter.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HIGH_NEED_ITEMS = 24;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 305;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;

    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata   = '0;   // mirror_temp[15:0], ref_temp[31:16]
    logic                           s_tuser   = 1'b0; // command

    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [39:0]                    m_tdata;  // stable[0], setpoint_out[17:1], temp_diff[34:18]

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fssd_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [fssd_pkg::CFG_W-1:0]     cfg_data  = '0;

    // Pacing controls shared by the sender, the receiver and the sequence
    bit                 quiet_link    = 1'b0;  // no idling on either side
    bit                 tx_paced      = 1'b1;
    bit                 rx_paced      = 1'b1;
    bit                 stall_request = 1'b0;  // one long receiver hold-off

    fssd_tb_pkg::film_stability_tracker tracker = new();

    film_slope_stability_detector_core #(
        .WINDOW_DEPTH (fssd_tb_pkg::RING_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transfer on any channel
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one item after an optional idle gap; hold it until the transfer.
    // Valid only drops when a gap follows, so it never toggles within a step.
    task automatic send_item(input logic cmd, input logic [fssd_pkg::TEMP_W-1:0] mir,
                             input logic [fssd_pkg::TEMP_W-1:0] rtemp);
        int gap;
        gap = (!quiet_link && tx_paced) ? $urandom_range(13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rtemp, mir};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_input(cmd, mir, rtemp);
    endtask

    // Pick mirror and reference temperatures with a given difference
    task automatic split_diff(input int delta, output logic [fssd_pkg::TEMP_W-1:0] mir,
                              output logic [fssd_pkg::TEMP_W-1:0] rtemp);
        int lo;
        int hi;
        int r;
        lo    = (delta > 0) ? -32768 : -32768 - delta;
        hi    = (delta > 0) ? 32767 - delta : 32767;
        r     = lo + int'($urandom_range(hi - lo));
        rtemp = r[fssd_pkg::TEMP_W-1:0];
        mir   = 16'(r + delta);
    endtask

    task automatic send_diff(input int delta);
        logic [fssd_pkg::TEMP_W-1:0] mir;
        logic [fssd_pkg::TEMP_W-1:0] rtemp;
        split_diff(delta, mir, rtemp);
        send_item(fssd_pkg::CMD_SAMPLE, mir, rtemp);
    endtask

    // Release the input and wait until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration side
    // ------------------------------------------------------------------------

    // Hold valid across back-to-back writes; drop it after the last one
    task automatic write_reg(input logic [fssd_pkg::IDX_W-1:0] idx,
                             input logic [fssd_pkg::CFG_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (last)
            cfg_valid <= 1'b0;
        tracker.write_reg(idx, val);
    endtask

    task automatic configure(input logic [fssd_pkg::CFG_W-1:0] lim,
                             input logic [fssd_pkg::CFG_W-1:0] need,
                             input logic [fssd_pkg::CFG_W-1:0] sp,
                             input bit poke_unmapped);
        if (poke_unmapped)
            write_reg(fssd_tb_pkg::REG_UNMAPPED, 16'($urandom), 1'b0);
        write_reg(fssd_pkg::REG_SLOPE_LIMIT, lim, 1'b0);
        write_reg(fssd_pkg::REG_STABLE_NEEDED, need, 1'b0);
        write_reg(fssd_pkg::REG_FILM_SETPOINT, sp, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random phase: mostly temperature ramps whose slope sits near the limit,
    // so the run counter climbs and breaks; some clears and raw noise.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int count, input logic [fssd_pkg::CFG_W-1:0] lim);
        int run_left;
        int step;
        int level;
        int pick;
        int base;
        run_left = 0;
        step     = 0;
        level    = int'($urandom_range(2000)) - 1000;
        base     = int'(lim) / 10;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(40, 8);
                step     = base + int'($urandom_range(4)) - 2;
                if ($urandom_range(1))
                    step = -step;
                tx_paced = ($urandom_range(3) != 0);
                if ($urandom_range(3) == 0)
                    level = int'($urandom_range(131070)) - 65535;
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_item(fssd_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
            end else if (pick < 13) begin
                send_item(fssd_pkg::CMD_SAMPLE, 16'($urandom), 16'($urandom));
            end else begin
                // Hold the step exactly most of the time, jitter it otherwise
                level = level + step;
                if ($urandom_range(3) == 0)
                    level = level + int'($urandom_range(4)) - 2;
                if (level > 65535)
                    level = 65535;
                if (level < -65535)
                    level = -65535;
                send_diff(level);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int seen;
        seen = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = 0;
            if (stall_request) begin
                stall_request = 1'b0;
                gap = LONG_HOLD;
            end else if (!quiet_link && rx_paced) begin
                gap = $urandom_range(13);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.check_result(m_tdata);
            seen++;
            if (seen % 32 == 0)
                rx_paced = ($urandom_range(2) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [fssd_pkg::CFG_W-1:0] lim;
        int                         hold_diff;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset register values: extreme differences first
        send_item(fssd_pkg::CMD_SAMPLE, 16'h7FFF, 16'h8000);
        send_item(fssd_pkg::CMD_SAMPLE, 16'h8000, 16'h7FFF);
        // Clear with nonzero temperatures; they must be ignored
        send_item(fssd_pkg::CMD_CLEAR, 16'h8000, 16'h7FFF);
        // Constant difference: wrap the window and build up a stable run
        for (int k = 0; k < 18; k++)
            send_diff(100);
        send_item(fssd_pkg::CMD_CLEAR, 16'hFFFF, 16'h0000);
        drain_results();

        // Zero slope limit: never stable, even with a single sample
        configure(16'h0000, 16'h0001, 16'hFFFF, 1'b1);
        for (int k = 0; k < 3; k++)
            send_diff(-7);
        drain_results();

        // Largest limit and required count: the run climbs but never reports
        configure(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        quiet_link = 1'b1;
        send_item(fssd_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
        hold_diff = int'($urandom_range(131070)) - 65535;
        for (int k = 0; k < HIGH_NEED_ITEMS; k++)
            send_diff(hold_diff);
        drain_results();
        quiet_link = 1'b0;

        // Random phases under changing register settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    lim = 16'($urandom_range(200, 1));
                    configure(lim, 16'($urandom_range(8, 1)), 16'($urandom), 1'b1);
                end
                1: begin
                    // Zero required count: every sample result reports stable
                    lim = 16'hFFFF;
                    configure(lim, 16'h0000, 16'hFFFF, 1'b0);
                end
                default: begin
                    lim = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
                    configure(lim, 16'($urandom_range(12, 1)), 16'($urandom), 1'b0);
                end
            endcase
            // Fill the pipe against a stalled result side once
            if (p == 2)
                stall_request = 1'b1;
            run_random_phase(PHASE_ITEMS, lim);
            drain_results();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fssd_pkg.sv
sv/fssd_window.sv
sv/fssd_judge.sv
sv/film_slope_stability_detector_core.sv
tb/fssd_tb_pkg.sv
tb/tb_top.sv
